### rtl/core/assert_macros.svh
// Assertion macros shared by the generator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, suspended while reset is asserted.
`define MTG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define MTG_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/mtg_pkg.sv
// Package for the MT19937 generator: constants, item type, twist and temper.
// No dependencies; imported by mtg_front, mtg_back and the top level.
package mtg_pkg;

    localparam int STATE_WORDS_DEF = 624;
    localparam int TWIST_OFFSET    = 397;

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] LCG_MULT     = 32'd69069;
    localparam logic [31:0] DEFAULT_SEED = 32'd4357;

    localparam logic OP_RESEED = 1'b0;
    localparam logic OP_DRAW   = 1'b1;

    typedef struct packed {
        logic        is_draw;
        logic [31:0] seed;
    } item_t;

    function automatic logic [31:0] lcg_step(input logic [31:0] s);
        logic [31:0] p;
        p = s * LCG_MULT;
        return p + 32'd1;
    endfunction

    function automatic logic [31:0] twist_one(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
        logic [31:0] y;
        logic [31:0] r;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        r = far ^ (y >> 1);
        if (y[0])
        begin
            r = r ^ TWIST_MATRIX;
        end
        return r;
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] y);
        logic [31:0] t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        return t ^ (t >> 18);
    endfunction

endpackage

### rtl/core/mtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the generator state store.
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/mtg_front.sv
// Front end: accepts command items, classifies them and holds them in a
// two-entry queue. Depends on mtg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtg_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  logic           opcode,
    input  logic [31:0]    seed_value,
    output logic           q_valid,
    input  logic           q_ready,
    output mtg_pkg::item_t q_item
);
    import mtg_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    item_t      in_item;

    assign cmd_ready = (count_reg != 2'd2);
    assign q_valid   = (count_reg != 2'd0);
    assign q_item    = entry_reg[rd_ptr_reg];

    assign push = cmd_valid && cmd_ready;
    assign pop  = q_valid && q_ready;

    always_comb
    begin
        in_item.is_draw = (opcode == OP_DRAW);
        in_item.seed    = seed_value;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    // a push without a pop must grow the queue by exactly one
    `MTG_ASSERT(a_push_grows, clk, rst_n, (push && !pop) |=> (count_reg == 2'($past(count_reg) + 2'd1)), "queue count did not grow on push")

endmodule

### rtl/core/mtg_back.sv
// Back end: seed fill, in-place regeneration and tempered draws over the
// state store. Depends on mtg_pkg, mtg_ram and assert_macros.svh.
`include "assert_macros.svh"

module mtg_back #(
    parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  mtg_pkg::item_t q_item,
    output logic           word_valid,
    input  logic           word_ready,
    output logic [31:0]    random_word
);
    import mtg_pkg::*;

    localparam int ADDR_W   = $clog2(STATE_WORDS);
    localparam int POS_W    = $clog2(STATE_WORDS + 2);
    localparam int FAR_WRAP = STATE_WORDS - TWIST_OFFSET;

    localparam logic [POS_W-1:0]  POS_SPENT    = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_WORDS + 1);
    localparam logic [ADDR_W-1:0] LAST_IDX     = ADDR_W'(STATE_WORDS - 1);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_FILL     = 7'b0000010,
        ST_PRIME    = 7'b0000100,
        ST_PRIME_LD = 7'b0001000,
        ST_RG_RD    = 7'b0010000,
        ST_RG_WR    = 7'b0100000,
        ST_DRAW     = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic              phase_reg, phase_next;
    logic [31:0]       lcg_reg, lcg_next;
    logic [15:0]       hi_reg, hi_next;
    logic [31:0]       cur_reg, cur_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_word_reg, out_word_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic              rd_en_a, rd_en_b;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [31:0]       rdata_a, rdata_b;
    logic [ADDR_W-1:0] far_addr;
    logic              out_free;

    // two copies of the state, written together, give two reads a cycle
    mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_next (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (rd_en_a),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram_far (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (rd_en_b),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    assign out_free = !out_valid_reg || word_ready;
    assign far_addr = (k_reg < ADDR_W'(FAR_WRAP)) ? k_reg + ADDR_W'(TWIST_OFFSET)
                                                  : k_reg - ADDR_W'(FAR_WRAP);

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        phase_next     = phase_reg;
        lcg_next       = lcg_reg;
        hi_next        = hi_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !word_ready;
        out_word_next  = out_word_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = k_reg;
        ram_wdata      = '0;
        rd_en_a        = 1'b0;
        raddr_a        = k_reg;
        rd_en_b        = 1'b0;
        raddr_b        = far_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    priority if (!q_item.is_draw)
                    begin
                        q_ready    = 1'b1;
                        lcg_next   = q_item.seed;
                        k_next     = '0;
                        phase_next = 1'b0;
                        state_next = ST_FILL;
                    end
                    else if (pos_reg == POS_UNSEEDED)
                    begin
                        // draw before any seed: fill from the default, keep the item
                        lcg_next   = DEFAULT_SEED;
                        k_next     = '0;
                        phase_next = 1'b0;
                        state_next = ST_FILL;
                    end
                    else if (pos_reg == POS_SPENT)
                    begin
                        k_next     = '0;
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        q_ready    = 1'b1;
                        rd_en_a    = 1'b1;
                        raddr_a    = pos_reg[ADDR_W-1:0];
                        pos_next   = pos_reg + POS_W'(1);
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_FILL:
            begin
                lcg_next = lcg_step(lcg_reg);
                if (!phase_reg)
                begin
                    hi_next    = lcg_reg[31:16];
                    phase_next = 1'b1;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = {hi_reg, lcg_reg[31:16]};
                    phase_next = 1'b0;
                    if (k_reg == LAST_IDX)
                    begin
                        pos_next   = POS_SPENT;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + ADDR_W'(1);
                    end
                end
            end
            ST_PRIME:
            begin
                rd_en_a    = 1'b1;
                raddr_a    = '0;
                state_next = ST_PRIME_LD;
            end
            ST_PRIME_LD:
            begin
                cur_next   = rdata_a;
                state_next = ST_RG_RD;
            end
            ST_RG_RD:
            begin
                rd_en_a    = 1'b1;
                raddr_a    = (k_reg == LAST_IDX) ? '0 : k_reg + ADDR_W'(1);
                rd_en_b    = 1'b1;
                state_next = ST_RG_WR;
            end
            ST_RG_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = twist_one(cur_reg, rdata_a, rdata_b);
                cur_next  = rdata_a;
                if (k_reg == LAST_IDX)
                begin
                    pos_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + ADDR_W'(1);
                    state_next = ST_RG_RD;
                end
            end
            ST_DRAW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = temper(rdata_a);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_UNSEEDED;
            k_reg         <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg      <= lcg_next;
        hi_reg       <= hi_next;
        cur_reg      <= cur_next;
        out_word_reg <= out_word_next;
    end

    assign word_valid  = out_valid_reg;
    assign random_word = out_word_reg;

    `MTG_ASSERT(a_we_busy, clk, rst_n, ram_we |-> (state_reg == ST_FILL || state_reg == ST_RG_WR), "state write outside fill or regeneration")
    `MTG_ASSERT(a_draw_seeded, clk, rst_n, (rd_en_a && state_reg == ST_IDLE) |-> (pos_reg < POS_SPENT), "draw read from spent or unseeded state")
    `MTG_ASSERT(a_word_from_draw, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_DRAW), "result raised outside a draw")
    `MTG_NEVER(a_pos_range, clk, rst_n, pos_reg > POS_UNSEEDED, "position beyond the unseeded mark")

endmodule

### rtl/core/mersenne_twister_generator_unit.sv
// Top level of the MT19937 generator: command queue front end and state back end.
// Depends on mtg_pkg, mtg_front, mtg_back and mtg_ram.
//
// Channel  Handshake                 Payload       Item
// cmd      cmd_valid / cmd_ready     opcode        reseed (no result) or draw
//                                    seed_value    seed for a reseed
// word     word_valid / word_ready   random_word   one tempered word per draw
//
// A draw from live state reads the state RAM in ST_IDLE (registered read
// port), then tempers the word and loads the output register in ST_DRAW.
// A reseed fills 624 words, each from the top halves of two successive LCG
// states (one LCG multiply per cycle). The draw after every 624th word, or
// after a reseed, first regenerates the store in place, with a RAM read in
// ST_RG_RD before each write in ST_RG_WR; a first draw without a seed adds
// the fill. Reset clears the queue and marks the state unseeded; the RAM is
// not cleared. A stalled word output holds the back end, while the two-entry
// queue keeps taking commands until it is full.
module mersenne_twister_generator_unit #(
    parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic        opcode,
    input  logic [31:0] seed_value,
    output logic        word_valid,
    input  logic        word_ready,
    output logic [31:0] random_word
);
    import mtg_pkg::*;

    // queued item between the two halves
    item_t q_item;
    logic  q_valid;
    logic  q_ready;

    // accept and classify commands
    mtg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (opcode),
        .seed_value (seed_value),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    // seed, regenerate and draw
    mtg_back #(.STATE_WORDS(STATE_WORDS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .random_word (random_word)
    );

endmodule

### tb/sv/tb_mersenne_twister_generator_unit.sv
// Self-checking testbench for mersenne_twister_generator_unit (MT19937, 69069 seed fill).
// Depends on mtg_pkg for the opcodes and the state size; predicts every drawn word itself.
`timescale 1ns / 1ps

module tb_mersenne_twister_generator_unit;

    import mtg_pkg::OP_RESEED;
    import mtg_pkg::OP_DRAW;

    localparam int WORD_COUNT = mtg_pkg::STATE_WORDS_DEF;
    localparam int TWIST_GAP  = 397;

    // Generator constants, kept apart from the package so the prediction stands alone.
    localparam logic [31:0] TWIST_XOR     = 32'h9908_b0df;
    localparam logic [31:0] KEEP_TOP_BIT  = 32'h8000_0000;
    localparam logic [31:0] KEEP_LOW_BITS = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_MASK_B = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_MASK_C = 32'hefc6_0000;
    localparam logic [31:0] LCG_FACTOR    = 32'd69069;
    localparam logic [31:0] FALLBACK_SEED = 32'd4357;
    localparam logic [31:0] TOP_HALF      = 32'hffff_0000;

    // Stimulus sizes: total items, length of the calm tail, settle time at the end.
    localparam int ITEM_TARGET   = 1620;
    localparam int QUIET_TAIL    = 150;
    // The settle time leaves room for a reseed and for the regeneration after it.
    localparam int SETTLE_CYCLES = 3000;

    // Predicts each drawn word and checks the words that leave the block, in order.
    class twister_word_checker;
        logic [31:0] words [WORD_COUNT];
        int unsigned position;
        logic [31:0] awaited_words [$];
        int          errors;

        function new();
            position = WORD_COUNT + 1;
            errors   = 0;
            foreach (words[i])
                words[i] = '0;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        function void fill_from_seed(logic [31:0] seed);
            logic [31:0] s;
            logic [31:0] w;
            s = seed;
            for (int i = 0; i < WORD_COUNT; i++)
            begin
                w = s & TOP_HALF;
                s = s * LCG_FACTOR + 32'd1;
                w = w | ((s & TOP_HALF) >> 16);
                s = s * LCG_FACTOR + 32'd1;
                words[i] = w;
            end
            position = WORD_COUNT;
        endfunction

        function void refresh_words();
            logic [31:0] y;
            logic [31:0] r;
            for (int k = 0; k < WORD_COUNT; k++)
            begin
                y = (words[k] & KEEP_TOP_BIT) | (words[(k + 1) % WORD_COUNT] & KEEP_LOW_BITS);
                r = words[(k + TWIST_GAP) % WORD_COUNT] ^ (y >> 1);
                if (y[0])
                begin
                    r = r ^ TWIST_XOR;
                end
                words[k] = r;
            end
            position = 0;
        endfunction

        function logic [31:0] temper_word(logic [31:0] raw);
            logic [31:0] t;
            t = raw ^ (raw >> 11);
            t = t ^ ((t << 7) & TEMPER_MASK_B);
            t = t ^ ((t << 15) & TEMPER_MASK_C);
            return t ^ (t >> 18);
        endfunction

        // Advance the predicted state by one accepted command item.
        function void note_command(logic op, logic [31:0] seed);
            if (op == OP_RESEED)
            begin
                fill_from_seed(seed);
            end
            else
            begin
                if (position >= WORD_COUNT)
                begin
                    // A draw before any seed falls back to the default seed first.
                    if (position != WORD_COUNT)
                    begin
                        fill_from_seed(FALLBACK_SEED);
                    end
                    refresh_words();
                end
                awaited_words.push_back(temper_word(words[position]));
                position++;
            end
        endfunction

        task flag_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_word(logic [31:0] got);
            logic [31:0] want;
            if (awaited_words.size() == 0)
            begin
                flag_mismatch($sformatf("random_word %h arrived with no draw outstanding", got));
            end
            else
            begin
                want = awaited_words.pop_front();
                if (got !== want)
                begin
                    flag_mismatch($sformatf("random_word got %h, expected %h", got, want));
                end
            end
        endtask

        task check_leftovers();
            if (awaited_words.size() != 0)
            begin
                flag_mismatch($sformatf("%0d drawn words never arrived", awaited_words.size()));
            end
        endtask
    endclass

    // Drive every input to a known level from time zero.
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cmd_valid  = 1'b0;
    logic        cmd_ready;
    logic        opcode     = OP_RESEED;
    logic [31:0] seed_value = '0;
    logic        word_valid;
    logic        word_ready = 1'b0;
    logic [31:0] random_word;

    twister_word_checker checker_sb;

    // Idle controls: idle_off silences both sides for the tail of the run,
    // sender_calm gives whole stretches with no sender gaps.
    bit idle_off    = 1'b0;
    bit sender_calm = 1'b0;
    int cmds_sent   = 0;

    mersenne_twister_generator_unit #(
        .STATE_WORDS (WORD_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .opcode      (opcode),
        .seed_value  (seed_value),
        .word_valid  (word_valid),
        .word_ready  (word_ready),
        .random_word (random_word)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Sometimes hold off one command item by a random gap, then present it and wait for the handshake.
    // The prediction moves on at the very edge that takes the item.
    task automatic push_command(input logic op, input logic [31:0] seed);
        int gap;
        gap = 0;
        if (!idle_off && !sender_calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
        end
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        opcode     <= op;
        seed_value <= seed;
        @(posedge clk);
        while (!cmd_ready)
        begin
            @(posedge clk);
        end
        checker_sb.note_command(op, seed);
        cmds_sent++;
        if (cmds_sent >= ITEM_TARGET - QUIET_TAIL)
        begin
            idle_off = 1'b1;
        end
    endtask

    // Drop valid and wait until every predicted word has come out.
    // Always wait one edge, so valid is never lowered and raised in the same step.
    task automatic drain_words();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (checker_sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Word side: unless idle_off is set, stall in random bursts between open stretches.
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!idle_off && $urandom_range(0, 3) == 0)
            begin
                word_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            word_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // Check every word taken at an edge with valid and ready both high.
    always @(posedge clk)
    begin
        if (rst_n && word_valid && word_ready)
        begin
            checker_sb.check_word(random_word);
        end
    end

    // Guard against a hang. The limit allows several times the slowest correct run.
    initial
    begin
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int          n_draws;
        int          n_reseeds;
        bit          first_segment;
        logic [31:0] seed;

        checker_sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Draw before any seed: the block must fall back to the default seed.
        // The seed field is ignored on a draw, so drive both extremes there.
        push_command(OP_DRAW, 32'hffff_ffff);
        push_command(OP_DRAW, 32'h0000_0000);
        push_command(OP_DRAW, $urandom);
        // Pause the sender until every word is home.
        drain_words();

        // Extreme seeds; the next draw after each must regenerate.
        push_command(OP_RESEED, 32'h0000_0000);
        repeat (3) push_command(OP_DRAW, $urandom);
        // Back-to-back reseeds: only the last one counts.
        push_command(OP_RESEED, 32'hffff_ffff);
        push_command(OP_RESEED, 32'h0000_0001);
        repeat (3) push_command(OP_DRAW, $urandom);
        push_command(OP_RESEED, 32'h8000_0000);
        repeat (2) push_command(OP_DRAW, $urandom);
        // Explicit reseed with the fallback value.
        push_command(OP_RESEED, FALLBACK_SEED);
        repeat (2) push_command(OP_DRAW, $urandom);
        push_command(OP_RESEED, $urandom);
        repeat (2) push_command(OP_DRAW, $urandom);

        // Random part: reseed, then a run of draws. Long runs cross the
        // 624-word boundary and force regeneration mid-stream; the first
        // run is always long so that happens at least once.
        first_segment = 1'b1;
        while (cmds_sent < ITEM_TARGET)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            n_reseeds   = ($urandom_range(0, 4) == 0) ? 2 : 1;
            repeat (n_reseeds)
            begin
                case ($urandom_range(0, 7))
                    0:       seed = 32'h0000_0000;
                    1:       seed = 32'hffff_ffff;
                    2:       seed = 32'h1 << $urandom_range(0, 31);
                    default: seed = $urandom;
                endcase
                push_command(OP_RESEED, seed);
            end
            if (first_segment || $urandom_range(0, 3) == 0)
            begin
                n_draws = $urandom_range(630, 1300);
            end
            else
            begin
                n_draws = $urandom_range(10, 80);
            end
            first_segment = 1'b0;
            repeat (n_draws)
            begin
                if (cmds_sent < ITEM_TARGET)
                begin
                    push_command(OP_DRAW, $urandom);
                end
            end
            if (!idle_off && $urandom_range(0, 5) == 0)
            begin
                drain_words();
            end
        end
        cmd_valid <= 1'b0;

        // Wait for the last words, then give a trailing reseed time to finish
        // so that any stray word would still be caught.
        while (checker_sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        checker_sb.check_leftovers();

        if (checker_sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mtg_pkg.sv
rtl/core/mtg_ram.sv
rtl/core/mtg_front.sv
rtl/core/mtg_back.sv
rtl/core/mersenne_twister_generator_unit.sv
tb/sv/tb_mersenne_twister_generator_unit.sv
